[hw/rtl/eau_pkg.sv]
// Shared codes and constants of the elementwise activation unit.
package eau_pkg;

   localparam int KIND_WIDTH = 3;

   typedef logic [KIND_WIDTH-1:0] kind_type;

   localparam kind_type KIND_NONE    = 3'd0;
   localparam kind_type KIND_LINEAR  = 3'd1;
   localparam kind_type KIND_SIGMOID = 3'd2;
   localparam kind_type KIND_TANH    = 3'd3;
   localparam kind_type KIND_RELU    = 3'd4;
   localparam kind_type KIND_LEAKY   = 3'd5;

   localparam logic CMD_FORWARD  = 1'b0;
   localparam logic CMD_BACKWARD = 1'b1;

   localparam int LEAKY_NUM   = 41;
   localparam int LEAKY_SHIFT = 12;

endpackage

[hw/rtl/elementwise_activation_unit.sv]
// Pipelined forward and backward activation unit for signed fixed-point elements.

// The unit takes one element per clock: busy is always low, and every beat
// accepted on start returns exactly one beat on rsp_valid, in order. Five
// register stages (input capture, sigmoid segments with the derivative and
// leaky products, derivative rounding, the gradient product, final rounding
// and saturation); all but the second hold one multiplier at most. The user
// must write the activation kind through csr_write_enable only while no
// beat is in flight; the block does not enforce it. Results never stall.
module elementwise_activation_unit #(
   parameter int DATA_WIDTH    = 16,
   parameter int FRACTION_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic signed [DATA_WIDTH-1:0]  req_x_value,
   input  logic signed [DATA_WIDTH-1:0]  req_saved_value,
   input  logic signed [DATA_WIDTH-1:0]  req_upstream_gradient,
   output logic                          rsp_valid,
   output logic signed [DATA_WIDTH-1:0]  rsp_result_value,
   input  logic                          csr_write_enable,
   input  logic [eau_pkg::KIND_WIDTH-1:0] csr_write_data
);
   import eau_pkg::*;

   localparam int D   = DATA_WIDTH;
   localparam int F   = FRACTION_BITS;
   localparam int TW  = D + 1;
   localparam int SW  = ((TW > F + 4) ? TW : F + 4) + 1;
   localparam int MW  = ((D > F) ? D : F) + 3;
   localparam int P1W = D + MW;
   localparam int LW  = D + 8;
   localparam int WW  = 2 * D + F + 2;

   localparam logic [SW-1:0] ONE_S  = SW'(1) << F;
   localparam logic [SW-1:0] T5_S   = SW'(5) << F;
   localparam logic [SW-1:0] T2_S   = (SW'(19) << F) >> 3;
   localparam logic [SW-1:0] C27_S  = (SW'(27) << F) >> 5;
   localparam logic [SW-1:0] C5_S   = (SW'(5) << F) >> 3;
   localparam logic [SW-1:0] HALF_S = ONE_S >> 1;

   localparam logic signed [MW-1:0]  ONE_M  = MW'(1) <<< F;
   localparam logic signed [P1W-1:0] HALF_P = P1W'(1) <<< (F - 1);
   localparam logic signed [WW-1:0]  ONE_W  = WW'(1) <<< F;
   localparam logic signed [WW-1:0]  HALF_W = WW'(1) <<< (F - 1);
   localparam logic signed [WW-1:0]  MAX_W  = (WW'(1) <<< (D - 1)) - WW'(1);
   localparam logic signed [WW-1:0]  MIN_W  = -MAX_W - WW'(1);

   localparam logic signed [LW-1:0] LEAKY_K    = LW'(LEAKY_NUM);
   localparam logic signed [LW-1:0] LEAKY_HALF = LW'(1) <<< (LEAKY_SHIFT - 1);

   function automatic logic signed [D-1:0] sat_d(input logic signed [WW-1:0] v);
      logic signed [D-1:0] r;
      if (v > MAX_W) begin
         r = MAX_W[D-1:0];
      end else if (v < MIN_W) begin
         r = MIN_W[D-1:0];
      end else begin
         r = v[D-1:0];
      end
      return r;
   endfunction

   kind_type kind_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;

   // Stage 1: captured beat.
   logic                   cmd1_ff;
   kind_type               kind1_ff;
   logic signed [D-1:0]    x1_ff, sv1_ff, g1_ff;

   // Stage 2.
   logic                   cmd2_ff;
   kind_type               kind2_ff;
   logic signed [D-1:0]    x2_ff, g2_ff, lk2_ff;
   logic                   svpos2_ff;
   logic [F:0]             sig2_ff;
   logic signed [P1W-1:0]  p1_2_ff;

   // Stage 3.
   logic                   cmd3_ff;
   kind_type               kind3_ff;
   logic signed [D-1:0]    fwd3_ff, g3_ff, lk3_ff, d3_ff;
   logic                   svpos3_ff;

   // Stage 4.
   logic                   usemul4_ff;
   logic signed [D-1:0]    direct4_ff;
   logic signed [2*D-1:0]  p2_4_ff;

   logic signed [D-1:0]    rsp_result_ff;

   // Stage A logic.
   logic signed [TW-1:0]   t_a;
   logic                   neg_a;
   logic [TW-1:0]          abs_a;
   logic [SW-1:0]          ae_a, y_a, s_a;
   logic signed [MW-1:0]   svm_a, op_a;
   logic signed [P1W-1:0]  p1_a;
   logic signed [D-1:0]    lv_a;
   logic signed [LW-1:0]   lsum_a;
   logic signed [D-1:0]    lk_a;
   logic                   svpos_a;

   // Stage B logic.
   logic signed [WW-1:0]   sigw_b, fwdw_b, draw_b, dw_b;
   logic signed [P1W-1:0]  dround_b;
   logic signed [D-1:0]    fwd_b, d_b;

   // Stage C logic.
   logic signed [D-1:0]    bw_c, direct_c;
   logic                   usemul_c;
   logic signed [2*D-1:0]  p2_c;

   // Stage D logic.
   logic signed [WW-1:0]   r_d;
   logic signed [D-1:0]    res_d;

   assign busy = 1'b0;

   always_comb begin
      t_a = (kind1_ff == KIND_TANH) ? (TW'(x1_ff) <<< 1) : TW'(x1_ff);
      neg_a = t_a[TW-1];
      abs_a = neg_a ? (~t_a + TW'(1)) : t_a;
      ae_a = SW'(abs_a);
      if (ae_a >= T5_S) begin
         y_a = ONE_S;
      end else if (ae_a >= T2_S) begin
         y_a = (ae_a >> 5) + C27_S;
      end else if (ae_a >= ONE_S) begin
         y_a = (ae_a >> 3) + C5_S;
      end else begin
         y_a = (ae_a >> 2) + HALF_S;
      end
      s_a = neg_a ? (ONE_S - y_a) : y_a;

      svm_a = MW'(sv1_ff);
      op_a = (kind1_ff == KIND_SIGMOID) ? (ONE_M - svm_a) : svm_a;
      p1_a = P1W'(sv1_ff) * P1W'(op_a);

      lv_a = (cmd1_ff == CMD_BACKWARD) ? g1_ff : x1_ff;
      lsum_a = (LW'(lv_a) * LEAKY_K + LEAKY_HALF) >>> LEAKY_SHIFT;
      lk_a = lsum_a[D-1:0];
      svpos_a = !sv1_ff[D-1] && (sv1_ff != '0);
   end

   always_comb begin
      sigw_b = signed'(WW'(sig2_ff));
      case (kind2_ff)
         KIND_SIGMOID: fwdw_b = sigw_b;
         KIND_TANH:    fwdw_b = (sigw_b <<< 1) - ONE_W;
         KIND_RELU:    fwdw_b = (!x2_ff[D-1] && (x2_ff != '0)) ? WW'(x2_ff) : '0;
         KIND_LEAKY:   fwdw_b = (!x2_ff[D-1] && (x2_ff != '0)) ? WW'(x2_ff) : WW'(lk2_ff);
         default:      fwdw_b = WW'(x2_ff);
      endcase
      fwd_b = sat_d(fwdw_b);

      dround_b = (p1_2_ff + HALF_P) >>> F;
      draw_b = WW'(dround_b);
      dw_b = (kind2_ff == KIND_TANH) ? (ONE_W - draw_b) : draw_b;
      d_b = sat_d(dw_b);
   end

   always_comb begin
      case (kind3_ff)
         KIND_RELU:  bw_c = svpos3_ff ? g3_ff : '0;
         KIND_LEAKY: bw_c = svpos3_ff ? g3_ff : lk3_ff;
         default:    bw_c = g3_ff;
      endcase
      direct_c = (cmd3_ff == CMD_BACKWARD) ? bw_c : fwd3_ff;
      usemul_c = (cmd3_ff == CMD_BACKWARD) &&
                 ((kind3_ff == KIND_SIGMOID) || (kind3_ff == KIND_TANH));
      p2_c = (2*D)'(g3_ff) * (2*D)'(d3_ff);
   end

   always_comb begin
      r_d = (WW'(p2_4_ff) + HALF_W) >>> F;
      res_d = usemul4_ff ? sat_d(r_d) : direct4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= KIND_NONE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            kind_ff <= csr_write_data;
         end
         v1_ff        <= start && !busy;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmd1_ff  <= req_command;
      kind1_ff <= kind_ff;
      x1_ff    <= req_x_value;
      sv1_ff   <= req_saved_value;
      g1_ff    <= req_upstream_gradient;

      cmd2_ff   <= cmd1_ff;
      kind2_ff  <= kind1_ff;
      x2_ff     <= x1_ff;
      g2_ff     <= g1_ff;
      lk2_ff    <= lk_a;
      svpos2_ff <= svpos_a;
      sig2_ff   <= s_a[F:0];
      p1_2_ff   <= p1_a;

      cmd3_ff   <= cmd2_ff;
      kind3_ff  <= kind2_ff;
      fwd3_ff   <= fwd_b;
      g3_ff     <= g2_ff;
      lk3_ff    <= lk2_ff;
      d3_ff     <= d_b;
      svpos3_ff <= svpos2_ff;

      usemul4_ff <= usemul_c;
      direct4_ff <= direct_c;
      p2_4_ff    <= p2_c;

      rsp_result_ff <= res_d;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_result_ff;

endmodule

[hw/rtl/eau_checker.sv]
// Port-level assertions for the elementwise activation unit and their binding.
module eau_checker #(
   parameter int DATA_WIDTH = 16
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_command,
   input logic signed [DATA_WIDTH-1:0] req_upstream_gradient,
   input logic                         rsp_valid,
   input logic signed [DATA_WIDTH-1:0] rsp_result_value
);
   import eau_pkg::*;

   // Every accepted beat returns its result after a fixed latency.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##4 rsp_valid)
      else $error("accepted beat produced no result");

   // No result appears without a beat accepted earlier.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset, 5))
      else $error("result beat without a matching request");

   // A zero gradient propagates as zero under every activation kind.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == CMD_BACKWARD) && (req_upstream_gradient == '0))
      |-> ##5 (rsp_result_value == '0))
      else $error("zero gradient did not give a zero result");

   assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("unit reported busy");

endmodule

bind elementwise_activation_unit eau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_eau_checker (
   .clock                 (clock),
   .reset                 (reset),
   .start                 (start),
   .busy                  (busy),
   .req_command           (req_command),
   .req_upstream_gradient (req_upstream_gradient),
   .rsp_valid             (rsp_valid),
   .rsp_result_value      (rsp_result_value)
);

[tb/elementwise_activation_unit_tb.sv]
// Self-checking testbench for the elementwise activation unit: directed table, then random beats.
`timescale 1ns / 1ps

module elementwise_activation_unit_tb;
   import eau_pkg::*;

   localparam int DW = 16;
   localparam int FRAC = 12;
   localparam longint ONE_Q = longint'(1) << FRAC;
   localparam longint HALF_Q = ONE_Q >>> 1;
   localparam longint MAX_Q = (longint'(1) << (DW - 1)) - 1;
   localparam longint MIN_Q = -MAX_Q - 1;
   localparam int NUM_KINDS = 8;
   localparam kind_type KIND_SPARE6 = 3'd6;
   localparam kind_type KIND_SPARE7 = 3'd7;
   localparam int RANDOM_PHASES = 11;
   localparam int BEATS_PER_PHASE = 50;

   typedef logic signed [DW-1:0] elem_type;

   typedef struct packed {
      kind_type kind;
      logic     cmd;
      elem_type x_value;
      elem_type saved_value;
      elem_type gradient;
      logic     known;
      elem_type want;
   } stim_row_type;

   logic     clock;
   logic     reset;
   logic     start;
   logic     busy;
   logic     req_command;
   elem_type req_x_value;
   elem_type req_saved_value;
   elem_type req_upstream_gradient;
   logic     rsp_valid;
   elem_type rsp_result_value;
   logic     csr_write_enable;
   kind_type csr_write_data;

   elem_type     expected_activations[$];
   stim_row_type directed_rows[$];
   kind_type     active_kind;
   kind_type     drv_kind;
   logic         next_known;
   elem_type     next_want;
   int           beats_in;
   int           results_seen;
   int           mismatches;
   int           forward_beats;
   int           backward_beats;
   int           kind_writes;
   logic [NUM_KINDS-1:0] kinds_seen;

   elementwise_activation_unit #(
      .DATA_WIDTH   (DW),
      .FRACTION_BITS(FRAC)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_command          (req_command),
      .req_x_value          (req_x_value),
      .req_saved_value      (req_saved_value),
      .req_upstream_gradient(req_upstream_gradient),
      .rsp_valid            (rsp_valid),
      .rsp_result_value     (rsp_result_value),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   function automatic longint clamp_q(longint v);
      if (v > MAX_Q) return MAX_Q;
      if (v < MIN_Q) return MIN_Q;
      return v;
   endfunction

   function automatic longint round_mul_q(longint a, longint b);
      return (a * b + HALF_Q) >>> FRAC;
   endfunction

   function automatic longint leaky_scale(longint v);
      return (v * LEAKY_NUM + (longint'(1) << (LEAKY_SHIFT - 1))) >>> LEAKY_SHIFT;
   endfunction

   function automatic longint sigmoid_q(longint v);
      longint mag;
      longint y;
      mag = (v < 0) ? -v : v;
      if (mag >= 5 * ONE_Q) y = ONE_Q;
      else if (mag >= ((19 * ONE_Q) >>> 3)) y = (mag >>> 5) + ((27 * ONE_Q) >>> 5);
      else if (mag >= ONE_Q) y = (mag >>> 3) + ((5 * ONE_Q) >>> 3);
      else y = (mag >>> 2) + (ONE_Q >>> 1);
      return (v < 0) ? ONE_Q - y : y;
   endfunction

   function automatic elem_type activation_or_gradient(kind_type kind, logic cmd, elem_type xv,
                                                       elem_type sv, elem_type gv);
      longint   x;
      longint   s;
      longint   g;
      longint   r;
      elem_type out;
      x = xv;
      s = sv;
      g = gv;
      if (cmd == CMD_FORWARD) begin
         case (kind)
            KIND_SIGMOID: r = sigmoid_q(x);
            KIND_TANH:    r = 2 * sigmoid_q(2 * x) - ONE_Q;
            KIND_RELU:    r = (x > 0) ? x : 0;
            KIND_LEAKY:   r = (x > 0) ? x : leaky_scale(x);
            default:      r = x;
         endcase
      end else begin
         case (kind)
            KIND_SIGMOID: r = round_mul_q(g, clamp_q(round_mul_q(s, ONE_Q - s)));
            KIND_TANH:    r = round_mul_q(g, clamp_q(ONE_Q - round_mul_q(s, s)));
            KIND_RELU:    r = (s > 0) ? g : 0;
            KIND_LEAKY:   r = (s > 0) ? g : leaky_scale(g);
            default:      r = g;
         endcase
      end
      out = elem_type'(clamp_q(r));
      return out;
   endfunction

   function automatic elem_type random_element();
      int pick;
      int bound;
      elem_type v;
      pick = $urandom_range(0, 5);
      case (pick)
         1: begin
            case ($urandom_range(0, 4))
               0: v = elem_type'(MIN_Q);
               1: v = elem_type'(MAX_Q);
               2: v = 0;
               3: v = -1;
               default: v = 1;
            endcase
         end
         2: begin
            case ($urandom_range(0, 5))
               0: bound = int'(ONE_Q);
               1: bound = int'((19 * ONE_Q) >>> 3);
               2: bound = int'(5 * ONE_Q);
               3: bound = int'(ONE_Q >>> 1);
               4: bound = int'((19 * ONE_Q) >>> 4);
               default: bound = int'((5 * ONE_Q) >>> 1);
            endcase
            bound = bound + $urandom_range(0, 6) - 3;
            v = elem_type'($urandom_range(0, 1) ? -bound : bound);
         end
         3: v = elem_type'(int'($urandom_range(0, 2 * ONE_Q)) - int'(ONE_Q));
         default: v = elem_type'($urandom);
      endcase
      return v;
   endfunction

   function automatic void add_row(kind_type kind, logic cmd, elem_type xv, elem_type sv,
                                   elem_type gv, logic known, elem_type want);
      stim_row_type row;
      row.kind = kind;
      row.cmd = cmd;
      row.x_value = xv;
      row.saved_value = sv;
      row.gradient = gv;
      row.known = known;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("** elementwise_activation_unit: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         active_kind = KIND_NONE;
      end else begin
         if (csr_write_enable) active_kind = csr_write_data;
         if (rsp_valid) begin
            results_seen++;
            if (expected_activations.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result beat, expected none, actual %0d",
                        $time, rsp_result_value);
            end else begin
               elem_type want;
               want = expected_activations.pop_front();
               if (rsp_result_value !== want) begin
                  mismatches++;
                  $display("%0t: result_value mismatch, expected %0d, actual %0d",
                           $time, want, rsp_result_value);
               end
            end
         end
         if (start && !busy) begin
            beats_in++;
            kinds_seen[active_kind] = 1'b1;
            if (req_command == CMD_FORWARD) forward_beats++;
            else backward_beats++;
            expected_activations.push_back(next_known ? next_want :
               activation_or_gradient(active_kind, req_command, req_x_value,
                                      req_saved_value, req_upstream_gradient));
         end
      end
   end

   task automatic send_beat(logic cmd, elem_type xv, elem_type sv, elem_type gv, logic known,
                            elem_type want);
      int taken;
      taken = beats_in;
      start = 1'b1;
      req_command = cmd;
      req_x_value = xv;
      req_saved_value = sv;
      req_upstream_gradient = gv;
      next_known = known;
      next_want = want;
      do @(negedge clock); while (beats_in == taken);
   endtask

   task automatic idle_for(int cycles);
      if (cycles > 0) begin
         start = 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      start = 1'b0;
      while (expected_activations.size() != 0) @(negedge clock);
   endtask

   task automatic write_kind(kind_type kind);
      drain_results();
      csr_write_enable = 1'b1;
      csr_write_data = kind;
      @(negedge clock);
      csr_write_enable = 1'b0;
      drv_kind = kind;
      kind_writes++;
   endtask

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   initial begin
      stim_row_type row;
      kind_type     kind;
      bit           dense;
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_FORWARD;
      req_x_value = 0;
      req_saved_value = 0;
      req_upstream_gradient = 0;
      csr_write_enable = 1'b0;
      csr_write_data = KIND_NONE;
      next_known = 1'b0;
      next_want = 0;
      drv_kind = KIND_NONE;
      active_kind = KIND_NONE;
      beats_in = 0;
      results_seen = 0;
      mismatches = 0;
      forward_beats = 0;
      backward_beats = 0;
      kind_writes = 0;
      kinds_seen = '0;

      add_row(KIND_NONE, CMD_FORWARD, 32767, 0, 0, 1, 32767);
      add_row(KIND_NONE, CMD_FORWARD, -32768, 0, 0, 1, -32768);
      add_row(KIND_NONE, CMD_BACKWARD, 1234, 77, -32768, 1, -32768);
      add_row(KIND_LINEAR, CMD_FORWARD, 12345, -1, 9, 1, 12345);
      add_row(KIND_LINEAR, CMD_BACKWARD, -32768, 5, 32767, 1, 32767);
      add_row(KIND_SIGMOID, CMD_FORWARD, 32767, 0, 0, 1, 4096);
      add_row(KIND_SIGMOID, CMD_FORWARD, -32768, 0, 0, 1, 0);
      add_row(KIND_SIGMOID, CMD_FORWARD, 0, 0, 0, 1, 2048);
      add_row(KIND_SIGMOID, CMD_FORWARD, 4096, 0, 0, 0, 0);
      add_row(KIND_SIGMOID, CMD_FORWARD, -9728, 0, 0, 0, 0);
      add_row(KIND_SIGMOID, CMD_BACKWARD, 0, 2048, 32767, 0, 0);
      add_row(KIND_SIGMOID, CMD_BACKWARD, 0, -32768, -32768, 0, 0);
      add_row(KIND_TANH, CMD_FORWARD, 32767, 0, 0, 1, 4096);
      add_row(KIND_TANH, CMD_FORWARD, -32768, 0, 0, 1, -4096);
      add_row(KIND_TANH, CMD_FORWARD, 0, 0, 0, 1, 0);
      add_row(KIND_TANH, CMD_BACKWARD, 0, 32767, 32767, 0, 0);
      add_row(KIND_TANH, CMD_BACKWARD, 0, 0, -32768, 1, -32768);
      add_row(KIND_RELU, CMD_FORWARD, -1, 0, 0, 1, 0);
      add_row(KIND_RELU, CMD_FORWARD, 1, 0, 0, 1, 1);
      add_row(KIND_RELU, CMD_BACKWARD, 0, 0, 5000, 1, 0);
      add_row(KIND_RELU, CMD_BACKWARD, 0, 1, -32768, 1, -32768);
      add_row(KIND_LEAKY, CMD_FORWARD, -32768, 0, 0, 0, 0);
      add_row(KIND_LEAKY, CMD_FORWARD, 32767, 0, 0, 1, 32767);
      add_row(KIND_LEAKY, CMD_BACKWARD, 0, -1, 32767, 0, 0);
      add_row(KIND_LEAKY, CMD_BACKWARD, 0, 32767, -5, 1, -5);
      add_row(KIND_SPARE7, CMD_FORWARD, -32768, 3, 3, 1, -32768);
      add_row(KIND_SPARE6, CMD_BACKWARD, 3, -3, 32767, 1, 32767);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind != drv_kind) write_kind(row.kind);
         send_beat(row.cmd, row.x_value, row.saved_value, row.gradient, row.known, row.want);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         kind = (p < NUM_KINDS) ? kind_type'(p) : kind_type'($urandom_range(0, NUM_KINDS - 1));
         dense = (p % 3 == 1);
         write_kind(kind);
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            if (!dense) idle_for(random_gap());
            if ($urandom_range(0, 59) == 0) drain_results();
            send_beat($urandom_range(0, 1) ? CMD_BACKWARD : CMD_FORWARD, random_element(),
                      random_element(), random_element(), 1'b0, 0);
         end
      end

      drain_results();
      repeat (10) @(negedge clock);

      $display("Sent %0d forward and %0d backward beats under kinds %b (bit per kind),",
               forward_beats, backward_beats, kinds_seen);
      $display("with %0d kind writes; %0d results checked, %0d mismatches.",
               kind_writes, results_seen, mismatches);
      if (mismatches == 0 && expected_activations.size() == 0) begin
         $display("** elementwise_activation_unit: PASSED **");
      end else begin
         $display("** elementwise_activation_unit: FAILED **");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/eau_pkg.sv
hw/rtl/elementwise_activation_unit.sv
hw/rtl/eau_checker.sv
tb/elementwise_activation_unit_tb.sv
